[design/dd_pkg.sv]
// Shared constants, codes and types of the deadlock detector.
`default_nettype none

package dd_pkg;

  localparam int unsigned MAX_PROCESSES = 16;
  localparam int unsigned MAX_RESOURCES = 8;
  localparam int unsigned AMOUNT_WIDTH  = 12;
  localparam int unsigned AVAIL_WIDTH   = 16;

  localparam int unsigned PROC_W     = $clog2(MAX_PROCESSES);
  localparam int unsigned RES_W      = $clog2(MAX_RESOURCES);
  localparam int unsigned PCOUNT_W   = $clog2(MAX_PROCESSES + 1);
  localparam int unsigned RCOUNT_W   = $clog2(MAX_RESOURCES + 1);
  localparam int unsigned MAT_DEPTH  = MAX_PROCESSES * MAX_RESOURCES;
  localparam int unsigned MAT_ADDR_W = PROC_W + RES_W;
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned CFG_DATA_W = PCOUNT_W;

  localparam logic [AVAIL_WIDTH-1:0] AVAIL_MAX = {AVAIL_WIDTH{1'b1}};

  localparam logic [CFG_ADDR_W-1:0] CFG_PROCESS_COUNT  = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_RESOURCE_COUNT = CFG_ADDR_W'(1);

  typedef enum logic [1:0] {
    OP_LOAD_AVAIL = 2'd0,
    OP_LOAD_ALLOC = 2'd1,
    OP_LOAD_REQ   = 2'd2,
    OP_RUN        = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_ADD,
    ST_EMIT
  } ctrl_state_e;

  // Port of the allocation and request memories.
  typedef struct packed {
    logic                    we_alloc;
    logic                    we_req;
    logic [MAT_ADDR_W-1:0]   waddr;
    logic [AMOUNT_WIDTH-1:0] wdata;
    logic                    re;
    logic [MAT_ADDR_W-1:0]   raddr;
  } mem_req_t;

  typedef struct packed {
    logic [PROC_W-1:0] process_id;
    logic              finished;
    logic              deadlocked;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

[design/dd_ram.sv]
// Simple dual-port RAM, one write and one registered read port.
`default_nettype none

module dd_ram #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned WIDTH = 12
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/dd_ctrl.sv]
// Detection sequencer: available vector, finished map and pass control.
`default_nettype none

module dd_ctrl (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output      logic                            in_ready_o,
  input  wire dd_pkg::op_e                     in_op_i,
  input  wire logic [dd_pkg::PROC_W-1:0]       in_proc_i,
  input  wire logic [dd_pkg::RES_W-1:0]        in_res_i,
  input  wire logic [dd_pkg::AMOUNT_WIDTH-1:0] in_amount_i,
  input  wire logic [dd_pkg::PCOUNT_W-1:0]     proc_count_i,
  input  wire logic [dd_pkg::RCOUNT_W-1:0]     res_count_i,
  output      dd_pkg::mem_req_t                mem_o,
  input  wire logic [dd_pkg::AMOUNT_WIDTH-1:0] alloc_rdata_i,
  input  wire logic [dd_pkg::AMOUNT_WIDTH-1:0] req_rdata_i,
  output      logic                            res_valid_o,
  input  wire logic                            res_ready_i,
  output      dd_pkg::result_t                 res_o
);
  import dd_pkg::*;

  ctrl_state_e state_q, state_d;

  logic [AVAIL_WIDTH-1:0]   avail_q [MAX_RESOURCES];
  logic [AVAIL_WIDTH-1:0]   avail_d [MAX_RESOURCES];
  logic [MAX_PROCESSES-1:0] done_q, done_d;
  logic [PCOUNT_W-1:0]      np_q, np_d, fin_q, fin_d;
  logic [RCOUNT_W-1:0]      nr_q, nr_d, iss_q, iss_d;
  logic [PROC_W-1:0]        p_q, p_d, e_q, e_d;
  logic [RES_W-1:0]         rr_q, rr_d;
  logic                     rv_q, rv_d, ok_q, ok_d, prog_q, prog_d;

  logic                     in_fire, issue, cmp_fail, ok_now, last_cmp;
  logic                     finish_now, prog_now, stop_run, proc_last, advance, e_last;
  logic [PCOUNT_W-1:0]      fin_now;
  logic [AMOUNT_WIDTH-1:0]  need;
  logic [AVAIL_WIDTH:0]     sum;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // Read pipeline over the resources of the current process.
  assign issue    = (state_q == ST_CHECK || state_q == ST_ADD) && (iss_q < nr_q);
  assign last_cmp = rv_q && (RCOUNT_W'(rr_q) == nr_q - RCOUNT_W'(1));
  assign need     = req_rdata_i - alloc_rdata_i;
  assign cmp_fail = (req_rdata_i > alloc_rdata_i) &&
                    (avail_q[rr_q] < AVAIL_WIDTH'(need));
  assign ok_now   = ok_q && !(rv_q && cmp_fail);
  assign sum      = {1'b0, avail_q[rr_q]} + (AVAIL_WIDTH + 1)'(alloc_rdata_i);

  assign finish_now = (state_q == ST_ADD) && last_cmp;
  assign fin_now    = fin_q + PCOUNT_W'(finish_now);
  assign prog_now   = prog_q || finish_now;
  assign stop_run   = !prog_now || (fin_now == np_q);
  assign proc_last  = (PCOUNT_W'(p_q) == np_q - PCOUNT_W'(1));
  assign advance    = (state_q == ST_SCAN && done_q[p_q]) ||
                      (state_q == ST_CHECK && last_cmp && !ok_now) ||
                      finish_now;
  assign e_last     = (PCOUNT_W'(e_q) == np_q - PCOUNT_W'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && in_op_i == OP_RUN) state_d = ST_SCAN;
      end
      ST_SCAN, ST_CHECK, ST_ADD: begin
        if (advance) begin
          state_d = (proc_last && stop_run) ? ST_EMIT : ST_SCAN;
        end else if (state_q == ST_SCAN) begin
          state_d = ST_CHECK;
        end else if (state_q == ST_CHECK && last_cmp) begin
          state_d = ST_ADD;
        end
      end
      ST_EMIT: begin
        if (res_ready_i && e_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    avail_d = avail_q;
    done_d  = done_q;
    np_d    = np_q;
    nr_d    = nr_q;
    fin_d   = fin_now;
    prog_d  = prog_now;
    p_d     = p_q;
    e_d     = e_q;
    iss_d   = iss_q + RCOUNT_W'(issue);
    rv_d    = issue;
    rr_d    = iss_q[RES_W-1:0];
    ok_d    = ok_now;

    mem_o.we_alloc = 1'b0;
    mem_o.we_req   = 1'b0;
    mem_o.waddr    = {in_proc_i, in_res_i};
    mem_o.wdata    = in_amount_i;
    mem_o.re       = issue;
    mem_o.raddr    = {p_q, iss_q[RES_W-1:0]};

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_op_i)
            OP_LOAD_AVAIL: avail_d[in_res_i] = AVAIL_WIDTH'(in_amount_i);
            OP_LOAD_ALLOC: mem_o.we_alloc = 1'b1;
            OP_LOAD_REQ:   mem_o.we_req = 1'b1;
            OP_RUN: begin
              if (proc_count_i == '0) np_d = PCOUNT_W'(1);
              else if (proc_count_i > PCOUNT_W'(MAX_PROCESSES)) np_d = PCOUNT_W'(MAX_PROCESSES);
              else np_d = proc_count_i;
              if (res_count_i == '0) nr_d = RCOUNT_W'(1);
              else if (res_count_i > RCOUNT_W'(MAX_RESOURCES)) nr_d = RCOUNT_W'(MAX_RESOURCES);
              else nr_d = res_count_i;
              done_d = '0;
              fin_d  = '0;
              prog_d = 1'b0;
              p_d    = '0;
              iss_d  = '0;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        iss_d = '0;
        rv_d  = 1'b0;
        ok_d  = 1'b1;
      end
      ST_CHECK: begin
        if (last_cmp) begin
          iss_d = '0;
          rv_d  = 1'b0;
        end
      end
      ST_ADD: begin
        if (rv_q) avail_d[rr_q] = sum[AVAIL_WIDTH] ? AVAIL_MAX : sum[AVAIL_WIDTH-1:0];
        if (finish_now) done_d[p_q] = 1'b1;
      end
      ST_EMIT: begin
        if (res_ready_i) e_d = e_q + PROC_W'(1);
      end
      default: ;
    endcase

    // Step to the next process; at the end of a pass start over or stop.
    if (advance) begin
      if (!proc_last) begin
        p_d = p_q + PROC_W'(1);
      end else if (!stop_run) begin
        p_d    = '0;
        prog_d = 1'b0;
      end else begin
        e_d = '0;
      end
    end
  end

  assign res_valid_o      = (state_q == ST_EMIT);
  assign res_o.process_id = e_q;
  assign res_o.finished   = done_q[e_q];
  assign res_o.deadlocked = (fin_q != np_q);
  assign res_o.last       = e_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      avail_q <= '{default: '0};
      done_q  <= '0;
      np_q    <= PCOUNT_W'(1);
      nr_q    <= RCOUNT_W'(1);
      fin_q   <= '0;
      prog_q  <= 1'b0;
      p_q     <= '0;
      e_q     <= '0;
      iss_q   <= '0;
      rv_q    <= 1'b0;
      rr_q    <= '0;
      ok_q    <= 1'b1;
    end else begin
      state_q <= state_d;
      avail_q <= avail_d;
      done_q  <= done_d;
      np_q    <= np_d;
      nr_q    <= nr_d;
      fin_q   <= fin_d;
      prog_q  <= prog_d;
      p_q     <= p_d;
      e_q     <= e_d;
      iss_q   <= iss_d;
      rv_q    <= rv_d;
      rr_q    <= rr_d;
      ok_q    <= ok_d;
    end
  end

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_ready_i && res_o.last |=> state_q == ST_IDLE)
    else $error("run did not end after last result");

  a_fin_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q <= np_q)
    else $error("finished count exceeds processes in use");

  a_issue_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss_q <= nr_q)
    else $error("read issue ran past resources in use");

  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_o.re |-> !(mem_o.we_alloc || mem_o.we_req))
    else $error("matrix load during a detection pass");

endmodule

`default_nettype wire

[design/deadlock_detector_unit.sv]
// Top level of the deadlock detector: ports, configuration and output register.
//
// Input stream: tuser[1:0] carries the operation (load available, load
// allocation, load request, run). A load writes one word and produces
// no result; tready is high whenever no run is in progress.
// A run clears the finished map and makes passes over the processes in use.
// Each unfinished process is checked by streaming its request and
// allocation words out of two RAMs with a registered read, one resource
// per cycle; if the process finishes, its allocation is added back into
// the available vector. After the passes the run gives one result per
// process at one per cycle while the receiver takes them.
// The configuration channel (cfg_index_i 0: process count, 1: resource
// count) is always ready; write it only while the block is idle.
// Results sit in an output register; while the receiver stalls it holds
// and the run waits. Reset clears the available vector and the finished
// map and sets both counts to one; the matrices are undefined until loaded.
`default_nettype none

module deadlock_detector_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output      logic                          s_axis_tready_o,
  // process_index[3:0], resource_index[6:4], amount[18:7], zero pad
  input  wire logic [23:0]                   s_axis_tdata_i,
  // operation[1:0]
  input  wire logic [1:0]                    s_axis_tuser_i,
  output      logic                          m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // process_id[3:0], finished[4], deadlocked[5], zero pad
  output      logic [7:0]                    m_axis_tdata_o,
  output      logic                          m_axis_tlast_o,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [dd_pkg::CFG_ADDR_W-1:0] cfg_index_i,
  input  wire logic [dd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import dd_pkg::*;

  logic [PCOUNT_W-1:0]     proc_count_q;
  logic [RCOUNT_W-1:0]     res_count_q;
  mem_req_t                mem;
  logic [AMOUNT_WIDTH-1:0] alloc_rdata, req_rdata;
  logic                    res_valid, res_ready;
  result_t                 res;
  logic                    m_valid_q;
  result_t                 m_res_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_count_q <= PCOUNT_W'(1);
      res_count_q  <= RCOUNT_W'(1);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_PROCESS_COUNT) proc_count_q <= cfg_data_i[PCOUNT_W-1:0];
      if (cfg_index_i == CFG_RESOURCE_COUNT) res_count_q <= cfg_data_i[RCOUNT_W-1:0];
    end
  end

  dd_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_op_i       (op_e'(s_axis_tuser_i)),
    .in_proc_i     (s_axis_tdata_i[3:0]),
    .in_res_i      (s_axis_tdata_i[6:4]),
    .in_amount_i   (s_axis_tdata_i[18:7]),
    .proc_count_i  (proc_count_q),
    .res_count_i   (res_count_q),
    .mem_o         (mem),
    .alloc_rdata_i (alloc_rdata),
    .req_rdata_i   (req_rdata),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  dd_ram #(.DEPTH(MAT_DEPTH), .WIDTH(AMOUNT_WIDTH)) u_alloc_ram (
    .clk_i   (clk_i),
    .we_i    (mem.we_alloc),
    .waddr_i (mem.waddr),
    .wdata_i (mem.wdata),
    .re_i    (mem.re),
    .raddr_i (mem.raddr),
    .rdata_o (alloc_rdata)
  );

  dd_ram #(.DEPTH(MAT_DEPTH), .WIDTH(AMOUNT_WIDTH)) u_req_ram (
    .clk_i   (clk_i),
    .we_i    (mem.we_req),
    .waddr_i (mem.waddr),
    .wdata_i (mem.wdata),
    .re_i    (mem.re),
    .raddr_i (mem.raddr),
    .rdata_o (req_rdata)
  );

  // Output register: refill when empty or when the held result transfers.
  assign res_ready = !m_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_ready) begin
      m_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) m_res_q <= res;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {2'b00, m_res_q.deadlocked, m_res_q.finished, m_res_q.process_id};
  assign m_axis_tlast_o  = m_res_q.last;

endmodule

`default_nettype wire

[tb/deadlock_detector_unit_tb.sv]
// Self-checking stream testbench of the deadlock detector: directed table, then random phases.
`timescale 1ns / 100ps

module deadlock_detector_unit_tb;
  import dd_pkg::*;

  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned STALL_LIMIT   = 20000;
  localparam int unsigned ITEM_TARGET   = 320;
  localparam logic [AMOUNT_WIDTH-1:0] AMOUNT_MAX = {AMOUNT_WIDTH{1'b1}};

  typedef enum logic [1:0] {
    SEQ_WELL,
    SEQ_FLOOD,
    SEQ_NOISE
  } seq_kind_e;

  typedef struct packed {
    op_e                     op;
    logic [PROC_W-1:0]       proc_idx;
    logic [RES_W-1:0]        res_idx;
    logic [AMOUNT_WIDTH-1:0] amount;
    logic                    typed;
    logic                    fin;
    logic                    dead;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [23:0]           s_axis_tdata_i;
  logic [1:0]            s_axis_tuser_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [7:0]            m_axis_tdata_o;
  logic                  m_axis_tlast_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Shadow state of the block
  logic [AVAIL_WIDTH-1:0]  avail_q [MAX_RESOURCES];
  logic [AMOUNT_WIDTH-1:0] alloc_q [MAX_PROCESSES][MAX_RESOURCES];
  logic [AMOUNT_WIDTH-1:0] req_q   [MAX_PROCESSES][MAX_RESOURCES];
  bit                      alloc_seen [MAX_PROCESSES][MAX_RESOURCES];
  bit                      req_seen   [MAX_PROCESSES][MAX_RESOURCES];
  logic [4:0]              proc_count_q;
  logic [3:0]              res_count_q;

  result_t     expected_q [$];
  int unsigned mismatches;
  int unsigned drawn_items;
  bit          send_burst;
  bit          hold_pending;

  stim_row_t directed_rows [21] = '{
    '{OP_LOAD_ALLOC, 4'd0,  3'd0, 12'd0,    1'b0, 1'b0, 1'b0},
    '{OP_LOAD_REQ,   4'd0,  3'd0, 12'd0,    1'b0, 1'b0, 1'b0},
    '{OP_RUN,        4'd0,  3'd0, 12'd0,    1'b1, 1'b1, 1'b0},
    '{OP_LOAD_REQ,   4'd0,  3'd0, 12'd4095, 1'b0, 1'b0, 1'b0},
    '{OP_RUN,        4'd15, 3'd7, 12'd4095, 1'b1, 1'b0, 1'b1},
    '{OP_LOAD_AVAIL, 4'd0,  3'd0, 12'd4094, 1'b0, 1'b0, 1'b0},
    '{OP_RUN,        4'd0,  3'd0, 12'd0,    1'b1, 1'b0, 1'b1},
    '{OP_LOAD_AVAIL, 4'd0,  3'd0, 12'd4095, 1'b0, 1'b0, 1'b0},
    '{OP_RUN,        4'd0,  3'd0, 12'd0,    1'b1, 1'b1, 1'b0},
    '{OP_LOAD_ALLOC, 4'd0,  3'd0, 12'd4095, 1'b0, 1'b0, 1'b0},
    '{OP_RUN,        4'd0,  3'd0, 12'd0,    1'b1, 1'b1, 1'b0},
    '{OP_LOAD_AVAIL, 4'd0,  3'd0, 12'd0,    1'b0, 1'b0, 1'b0},
    // request below allocation counts as no need
    '{OP_LOAD_REQ,   4'd0,  3'd0, 12'd0,    1'b0, 1'b0, 1'b0},
    '{OP_RUN,        4'd0,  3'd0, 12'd0,    1'b1, 1'b1, 1'b0},
    // loads beyond the counts in use are kept for later phases
    '{OP_LOAD_ALLOC, 4'd15, 3'd7, 12'd4095, 1'b0, 1'b0, 1'b0},
    '{OP_LOAD_REQ,   4'd15, 3'd7, 12'd4095, 1'b0, 1'b0, 1'b0},
    '{OP_LOAD_AVAIL, 4'd0,  3'd7, 12'd4095, 1'b0, 1'b0, 1'b0},
    '{OP_LOAD_ALLOC, 4'd0,  3'd0, 12'd1,    1'b0, 1'b0, 1'b0},
    '{OP_LOAD_REQ,   4'd0,  3'd0, 12'd9,    1'b0, 1'b0, 1'b0},
    '{OP_RUN,        4'd0,  3'd0, 12'd0,    1'b0, 1'b0, 1'b0},
    '{OP_RUN,        4'd5,  3'd2, 12'd2730, 1'b0, 1'b0, 1'b0}
  };

  deadlock_detector_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_count(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [AMOUNT_WIDTH-1:0] draw_amount();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return AMOUNT_MAX;
      2, 3, 4: return AMOUNT_WIDTH'($urandom_range(0, 15));
      default: return AMOUNT_WIDTH'($urandom_range(0, 4095));
    endcase
  endfunction

  // Apply one accepted item to the shadow state; a run queues its results.
  function automatic void apply_item(op_e op, logic [PROC_W-1:0] p, logic [RES_W-1:0] r,
                                     logic [AMOUNT_WIDTH-1:0] amt);
    int unsigned np;
    int unsigned nr;
    int unsigned done_cnt;
    bit          progress;
    bit          ok;
    logic [15:0] finished_set;
    logic [16:0] sum;
    result_t     res;
    case (op)
      OP_LOAD_AVAIL: avail_q[r] = AVAIL_WIDTH'(amt);
      OP_LOAD_ALLOC: begin
        alloc_q[p][r]    = amt;
        alloc_seen[p][r] = 1'b1;
      end
      OP_LOAD_REQ: begin
        req_q[p][r]    = amt;
        req_seen[p][r] = 1'b1;
      end
      default: begin
        np           = clamp_count(proc_count_q, MAX_PROCESSES);
        nr           = clamp_count(res_count_q, MAX_RESOURCES);
        finished_set = '0;
        done_cnt     = 0;
        progress     = 1'b1;
        while (progress && done_cnt < np) begin
          progress = 1'b0;
          for (int unsigned i = 0; i < np; i++) begin
            if (!finished_set[i]) begin
              ok = 1'b1;
              for (int unsigned j = 0; j < nr; j++) begin
                if (req_q[i][j] > alloc_q[i][j] &&
                    avail_q[j] < AVAIL_WIDTH'(req_q[i][j] - alloc_q[i][j]))
                  ok = 1'b0;
              end
              if (ok) begin
                finished_set[i] = 1'b1;
                done_cnt++;
                progress = 1'b1;
                // hand the allocation back, saturating
                for (int unsigned j = 0; j < nr; j++) begin
                  sum = {1'b0, avail_q[j]} + 17'(alloc_q[i][j]);
                  avail_q[j] = sum[16] ? AVAIL_MAX : sum[15:0];
                end
              end
            end
          end
        end
        for (int unsigned i = 0; i < np; i++) begin
          res.process_id = PROC_W'(i);
          res.finished   = finished_set[i];
          res.deadlocked = (done_cnt < np);
          res.last       = (i + 1 == np);
          expected_q.push_back(res);
        end
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatches < 100)
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic send_item(op_e op, logic [PROC_W-1:0] p, logic [RES_W-1:0] r,
                           logic [AMOUNT_WIDTH-1:0] amt);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = op;
    s_axis_tdata_i  = {5'd0, amt, r, p};
    do @(posedge clk_i); while (!s_axis_tready_o);
    apply_item(op, p, r, amt);
    drawn_items++;
  endtask

  // Send one item; before a run, load any matrix word in use that was never written.
  task automatic offer(op_e op, logic [PROC_W-1:0] p, logic [RES_W-1:0] r,
                       logic [AMOUNT_WIDTH-1:0] amt);
    int unsigned np;
    int unsigned nr;
    if (op == OP_RUN) begin
      np = clamp_count(proc_count_q, MAX_PROCESSES);
      nr = clamp_count(res_count_q, MAX_RESOURCES);
      for (int unsigned i = 0; i < np; i++) begin
        for (int unsigned j = 0; j < nr; j++) begin
          if (!alloc_seen[i][j]) send_item(OP_LOAD_ALLOC, PROC_W'(i), RES_W'(j), draw_amount());
          if (!req_seen[i][j]) send_item(OP_LOAD_REQ, PROC_W'(i), RES_W'(j), draw_amount());
        end
      end
    end
    send_item(op, p, r, amt);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_PROCESS_COUNT) proc_count_q = value;
    else res_count_q = value[3:0];
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Drop the input, wait for every expected result, then let the block go quiet.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Result receiver
  initial begin
    int unsigned wait_n;
    int unsigned taken;
    bit          burst;
    m_axis_tready_i = 1'b0;
    taken = 0;
    burst = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        wait_n       = HOLD_CYCLES;
      end else begin
        wait_n = burst ? 0 : $urandom_range(0, 4);
      end
      repeat (wait_n) begin
        @(negedge clk_i);
        m_axis_tready_i = 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready_i = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      taken++;
      if (taken % 40 == 0) burst = ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing expected", m_axis_tdata_o, 0);
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata_o[3:0] !== want.process_id)
          report_mismatch("process_id", m_axis_tdata_o[3:0], want.process_id);
        if (m_axis_tdata_o[4] !== want.finished)
          report_mismatch("finished", m_axis_tdata_o[4], want.finished);
        if (m_axis_tdata_o[5] !== want.deadlocked)
          report_mismatch("deadlocked", m_axis_tdata_o[5], want.deadlocked);
        if (m_axis_tlast_o !== want.last)
          report_mismatch("last", m_axis_tlast_o, want.last);
      end
    end
  end

  // Watchdog: count cycles without any transfer
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("deadlock_detector_unit_tb NOT OK");
    $finish;
  end

  initial begin
    stim_row_t   row;
    result_t     typed_res;
    seq_kind_e   kind;
    int unsigned phase;
    int unsigned n_runs;
    int unsigned np;
    int unsigned nr;
    logic [CFG_DATA_W-1:0] pc;
    logic [CFG_DATA_W-1:0] rc;
    logic [PROC_W-1:0]     p_sel;
    logic [RES_W-1:0]      r_sel;

    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = OP_LOAD_AVAIL;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_PROCESS_COUNT;
    cfg_data_i      = '0;
    mismatches      = 0;
    drawn_items     = 0;
    send_burst      = 1'b0;
    hold_pending    = 1'b0;
    proc_count_q    = 5'd1;
    res_count_q     = 4'd1;
    foreach (avail_q[j]) avail_q[j] = '0;
    foreach (alloc_seen[i, j]) begin
      alloc_seen[i][j] = 1'b0;
      req_seen[i][j]   = 1'b0;
      alloc_q[i][j]    = '0;
      req_q[i][j]      = '0;
    end
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, at the reset counts of one process and one resource
    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      send_item(row.op, row.proc_idx, row.res_idx, row.amount);
      if (row.typed) begin
        // take the hand-written answer in place of the computed one
        void'(expected_q.pop_back());
        typed_res = '{process_id: '0, finished: row.fin, deadlocked: row.dead, last: 1'b1};
        expected_q.push_back(typed_res);
      end
    end

    phase = 0;
    while (drawn_items < ITEM_TARGET || phase < 7) begin
      settle();
      if (phase == 4) kind = SEQ_FLOOD;
      else if (phase == 2 || phase == 3 || phase == 6) kind = SEQ_WELL;
      else begin
        case ($urandom_range(0, 9))
          0:       kind = SEQ_FLOOD;
          1:       kind = SEQ_NOISE;
          default: kind = SEQ_WELL;
        endcase
      end

      if (kind == SEQ_FLOOD) begin
        pc = 5'd16;
        rc = 5'($urandom_range(1, 2));
      end else begin
        case (phase)
          0: begin
            pc = 5'($urandom_range(1, 4));
            rc = 5'($urandom_range(1, 3));
          end
          2: begin
            pc = 5'd0;
            rc = 5'd0;
          end
          3: begin
            pc = 5'd8;
            rc = 5'd2;
          end
          6: begin
            pc = 5'd3;
            rc = 5'd8;
          end
          default: begin
            case ($urandom_range(0, 9))
              0:       pc = 5'd0;
              1:       pc = 5'd16;
              2:       pc = 5'($urandom_range(17, 31));
              3:       pc = 5'($urandom_range(5, 15));
              default: pc = 5'($urandom_range(1, 4));
            endcase
            case ($urandom_range(0, 9))
              0:       rc = 5'd0;
              1:       rc = 5'd8;
              2:       rc = 5'($urandom_range(9, 15));
              default: rc = 5'($urandom_range(1, 4));
            endcase
          end
        endcase
      end
      write_reg(CFG_PROCESS_COUNT, pc);
      write_reg(CFG_RESOURCE_COUNT, rc);
      np = clamp_count(proc_count_q, MAX_PROCESSES);
      nr = clamp_count(res_count_q, MAX_RESOURCES);
      send_burst = ($urandom_range(0, 3) == 0);
      // hold the receiver off so that queued runs back up into the input
      if (phase == 3) hold_pending = 1'b1;

      case (kind)
        SEQ_FLOOD: begin
          // every process holds the most, so repeated runs saturate available
          for (int unsigned i = 0; i < MAX_PROCESSES; i++) begin
            for (int unsigned j = 0; j < nr; j++) begin
              offer(OP_LOAD_ALLOC, PROC_W'(i), RES_W'(j), AMOUNT_MAX);
              offer(OP_LOAD_REQ, PROC_W'(i), RES_W'(j), draw_amount());
            end
          end
          repeat ($urandom_range(2, 3))
            offer(OP_RUN, PROC_W'($urandom), RES_W'($urandom), AMOUNT_WIDTH'($urandom));
        end
        SEQ_NOISE: begin
          repeat (10)
            offer(op_e'($urandom_range(0, 3)), PROC_W'($urandom), RES_W'($urandom),
                  AMOUNT_WIDTH'($urandom));
        end
        default: begin
          n_runs = (phase == 3) ? 4 : $urandom_range(1, 3);
          repeat (n_runs) begin
            repeat ($urandom_range(2, 8)) begin
              p_sel = ($urandom_range(0, 4) == 0) ? PROC_W'($urandom_range(0, 15))
                                                  : PROC_W'($urandom_range(0, np - 1));
              r_sel = ($urandom_range(0, 4) == 0) ? RES_W'($urandom_range(0, 7))
                                                  : RES_W'($urandom_range(0, nr - 1));
              offer(op_e'($urandom_range(0, 2)), p_sel, r_sel, draw_amount());
            end
            offer(OP_RUN, PROC_W'($urandom), RES_W'($urandom), AMOUNT_WIDTH'($urandom));
          end
        end
      endcase
      phase++;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("deadlock_detector_unit_tb OK");
    else
      $display("deadlock_detector_unit_tb NOT OK");
    $finish;
  end

endmodule

[deadlock_detector_unit.f]
design/dd_pkg.sv
design/dd_ram.sv
design/dd_ctrl.sv
design/deadlock_detector_unit.sv
tb/deadlock_detector_unit_tb.sv
